// ===== design/sdec_pkg.sv =====
// Shared types, constants and the CRC8 step for the scratchpad decoder.
`default_nettype none

package sdec_pkg;

  localparam logic [3:0] FRAME_LAST  = 4'd8;
  localparam logic [3:0] FRAME_BYTES = 4'd9;

  localparam logic [7:0] FAM_A = 8'h10;
  localparam logic [7:0] FAM_B = 8'h28;
  localparam logic [7:0] FAM_C = 8'h22;

  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [7:0] BYTE_ONES    = 8'hFF;
  localparam logic [7:0] CPD_EXTENDED = 8'h10;
  localparam logic [15:0] CR_BIAS     = 16'd12;

  localparam logic [1:0] RES_9B  = 2'b00;
  localparam logic [1:0] RES_10B = 2'b01;
  localparam logic [1:0] RES_11B = 2'b10;

  localparam logic [1:0] UNIT_C = 2'd0;
  localparam logic [1:0] UNIT_K = 2'd1;

  localparam logic signed [16:0] KELVIN_OFS = 17'sd4370;
  localparam logic signed [20:0] F_OFS_X5   = 21'sd2560;

  // floor(n / 5) == (n * DIV5_RECIP) >> DIV5_SHIFT for n below 2**22
  localparam logic [19:0] DIV5_RECIP = 20'd838861;
  localparam int          DIV5_SHIFT = 22;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_GONE    = 2'd2,
    ST_UNSUP   = 2'd3
  } sdec_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] family_code;
    logic       frame_start;
  } sdec_in_t;

  typedef struct packed {
    logic signed [16:0] temperature;
    sdec_status_e       status;
    logic [7:0]         computed_crc;
  } sdec_out_t;

  // One finished frame, classified by the front end
  typedef struct packed {
    sdec_status_e status;
    logic [7:0]   crc;
    logic         fam_a;
    logic [15:0]  reading;
    logic [1:0]   res_sel;
    logic [7:0]   count_remain;
    logic         cpd_ext;
  } sdec_rec_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sdec_front.sv =====
// Front end: counts frame bytes, runs the CRC, classifies each finished frame.
`default_nettype none

module sdec_front
  import sdec_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      acc_i,
  input  wire sdec_in_t  in_data_i,
  output logic           push_o,
  output sdec_rec_t      rec_o
);

  logic [3:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic        ones_q, ones_d;
  logic [7:0]  fam_q;
  logic [15:0] reading_q;
  logic [7:0]  res_q;
  logic [7:0]  cr_q;
  logic [7:0]  cpd_q;

  logic [3:0]  idx;
  logic        live;
  logic        first;
  logic [7:0]  crc_base;
  logic        ones_base;
  logic        ones_next;
  logic        fam_ok;

  always_comb begin
    idx       = in_data_i.frame_start ? 4'd0 : count_q;
    live      = acc_i && (idx <= FRAME_LAST);
    first     = (idx == 4'd0);
    crc_base  = first ? 8'd0 : crc_q;
    ones_base = first ? 1'b1 : ones_q;
    ones_next = ones_base && (in_data_i.data_byte == BYTE_ONES);
    count_d   = count_q;
    crc_d     = crc_q;
    ones_d    = ones_q;
    if (live) begin
      count_d = idx + 4'd1;
      ones_d  = ones_next;
      crc_d   = (idx == FRAME_LAST) ? crc_base : crc8_update(crc_base, in_data_i.data_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      crc_q   <= 8'd0;
      ones_q  <= 1'b1;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      ones_q  <= ones_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (live) begin
      unique case (idx)
        4'd0: begin
          fam_q           <= in_data_i.family_code;
          reading_q[7:0]  <= in_data_i.data_byte;
        end
        4'd1: reading_q[15:8] <= in_data_i.data_byte;
        4'd4: res_q           <= in_data_i.data_byte;
        4'd6: cr_q            <= in_data_i.data_byte;
        4'd7: cpd_q           <= in_data_i.data_byte;
        default: ;
      endcase
    end
  end

  // Classify on the ninth byte; the earlier bytes are already latched
  always_comb begin
    fam_ok = (fam_q == FAM_A) || (fam_q == FAM_B) || (fam_q == FAM_C);
    push_o = live && (idx == FRAME_LAST);
    if (!fam_ok) begin
      rec_o.status = ST_UNSUP;
    end else if (crc_q != in_data_i.data_byte) begin
      rec_o.status = ones_next ? ST_GONE : ST_CRC_ERR;
    end else begin
      rec_o.status = ST_OK;
    end
    rec_o.crc          = crc_q;
    rec_o.fam_a        = (fam_q == FAM_A);
    rec_o.reading      = reading_q;
    rec_o.res_sel      = res_q[6:5];
    rec_o.count_remain = cr_q;
    rec_o.cpd_ext      = (cpd_q == CPD_EXTENDED);
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FRAME_BYTES) else $error("byte count beyond frame length");
  a_push_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> count_q == FRAME_BYTES) else $error("frame push without frame end");
`endif

endmodule

`default_nettype wire

// ===== design/sdec_queue.sv =====
// Two-entry frame queue between the front end and the back end.
`default_nettype none

module sdec_queue
  import sdec_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire sdec_rec_t rec_i,
  output logic           full_o,
  output logic           valid_o,
  input  wire logic      pop_i,
  output sdec_rec_t      rec_o
);

  sdec_rec_t  mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && full_o)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== design/sdec_back.sv =====
// Back end: decodes the raw reading and scales it to the selected unit.
`default_nettype none

module sdec_back
  import sdec_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] unit_i,
  input  wire logic       q_valid_i,
  input  wire sdec_rec_t  q_rec_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output sdec_out_t       out_data_o
);

  logic adv;

  // Stage 1 registers
  logic               s1_valid_q;
  sdec_status_e       s1_status_q;
  logic [7:0]         s1_crc_q;
  logic signed [16:0] s1_direct_q;
  logic               s1_use_f_q;
  logic               s1_neg_q;
  logic [18:0]        s1_mag_q;

  logic               out_valid_q;
  sdec_out_t          out_q;

  logic [15:0]        raw;
  logic signed [16:0] raw_s;
  logic signed [20:0] raw_w;
  logic signed [20:0] f_num;
  logic signed [20:0] f_abs;
  logic signed [16:0] direct_d;
  logic               use_f_d;

  logic [38:0]        prod;
  logic [16:0]        quot;
  logic [16:0]        f_temp;

  // Advance the whole back end unless a finished result is held
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && q_valid_i;

  always_comb begin
    raw = q_rec_i.reading;
    if (q_rec_i.fam_a) begin
      raw = {q_rec_i.reading[12:0], 3'b000};
      if (q_rec_i.cpd_ext) begin
        raw = {raw[15:4], 4'b0000} + CR_BIAS - {8'd0, q_rec_i.count_remain};
      end
    end else begin
      unique case (q_rec_i.res_sel)
        RES_9B:  raw = {q_rec_i.reading[15:3], 3'b000};
        RES_10B: raw = {q_rec_i.reading[15:2], 2'b00};
        RES_11B: raw = {q_rec_i.reading[15:1], 1'b0};
        default: raw = q_rec_i.reading;
      endcase
    end
    raw_s = signed'({raw[15], raw});
    raw_w = signed'({{5{raw[15]}}, raw});
    f_num = (raw_w <<< 3) + raw_w + F_OFS_X5;
    f_abs = f_num[20] ? -f_num : f_num;
    use_f_d  = 1'b0;
    direct_d = 17'sd0;
    if (q_rec_i.status == ST_OK) begin
      unique case (unit_i)
        UNIT_C:  direct_d = raw_s;
        UNIT_K:  direct_d = raw_s + KELVIN_OFS;
        default: use_f_d  = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_status_q <= q_rec_i.status;
      s1_crc_q    <= q_rec_i.crc;
      s1_direct_q <= direct_d;
      s1_use_f_q  <= use_f_d;
      s1_neg_q    <= f_num[20];
      s1_mag_q    <= f_abs[18:0];
    end
  end

  // Divide the magnitude by five through the reciprocal, then restore the sign
  always_comb begin
    prod   = {20'd0, s1_mag_q} * {19'd0, DIV5_RECIP};
    quot   = prod[38:DIV5_SHIFT];
    f_temp = s1_neg_q ? (17'd0 - quot) : quot;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.status       <= s1_status_q;
      out_q.computed_crc <= s1_crc_q;
      out_q.temperature  <= s1_use_f_q ? signed'(f_temp) : s1_direct_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_err_zero_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> out_q.temperature == 17'sd0)
    else $error("nonzero temperature on error status");
  a_no_pop_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o) else $error("pop while output held");
`endif

endmodule

`default_nettype wire

// ===== design/temp_sensor_scratchpad_decoder.sv =====
// Scratchpad decoder top level: front end, frame queue, back end, unit register.
//
// Input channel: one scratchpad byte per transfer (in_valid_i / in_stall_o),
// with the family code and a frame start mark. A transfer with frame_start
// begins a new frame; bytes after the ninth are dropped until the next mark.
// Output channel: one result per complete frame (out_valid_o / out_stall_i)
// carrying the temperature in 1/16 degree, status and the computed CRC8.
// Throughput: one byte per cycle unless stalled, set by the combinational CRC.
// The ninth byte's transfer writes the frame into the queue; the back end
// decodes it into stage 1, and the divide-by-five multiply feeds the output.
// cfg_we_i writes unit_select (Celsius, Kelvin, Fahrenheit); write it idle.
// Reset clears the byte count, the CRC, the queue and the output, and
// selects Celsius.
// When the receiver stalls, the result holds and the back end halts; up to
// two further frames collect in the queue, after which in_stall_o rises.
`default_nettype none

module temp_sensor_scratchpad_decoder
  import sdec_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire sdec_in_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output sdec_out_t       out_data_o
);

  logic [1:0] unit_q;
  logic       acc;
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  sdec_rec_t  rec_in;
  sdec_rec_t  rec_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UNIT_C;
    end else if (cfg_we_i) begin
      unit_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full;
  assign acc        = in_valid_i && !in_stall_o;

  sdec_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .in_data_i (in_data_i),
    .push_o    (push),
    .rec_o     (rec_in)
  );

  sdec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rec_o   (rec_out)
  );

  sdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .unit_i      (unit_q),
    .q_valid_i   (q_valid),
    .q_rec_i     (rec_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the scratchpad decoder: byte-level stimulus with a self-checking predictor.
`timescale 1ns / 100ps

module tb;
  import sdec_pkg::*;

  localparam logic [1:0] UNIT_F     = 2'd2;
  localparam logic [1:0] UNIT_F_ALT = 2'd3;
  localparam int KELVIN_16THS  = 4370;
  localparam int F_BIAS_X5     = 2560;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 180;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  sdec_in_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  sdec_out_t  out_data_o;

  temp_sensor_scratchpad_decoder dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [1:0]  unit_sel = UNIT_C;
  logic [3:0]  pos      = 4'd0;
  logic [7:0]  crc_q    = 8'h00;
  logic [7:0]  fam_q;
  logic [15:0] reading_q;
  logic [7:0]  res_q;
  logic [7:0]  remain_q;
  logic [7:0]  cpd_q;
  logic        all_ff   = 1'b1;

  sdec_out_t readings_due[$];
  logic [7:0] pad [9];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fed_cnt       = 0;
  int results_seen  = 0;
  int n_errors      = 0;
  int quiet_cycles  = 0;
  int st_seen [4]   = '{0, 0, 0, 0};

  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Advance the frame tracker by one byte; queue the reading on the ninth
  task automatic predict_reading(input sdec_in_t it, output bit counted);
    logic [3:0]  idx;
    logic [15:0] r;
    int          raw;
    int          t;
    sdec_out_t   res;
    if (it.frame_start) begin
      pos = 4'd0;
    end
    counted = (pos < FRAME_BYTES);
    if (counted) begin
      idx = pos;
      if (idx == 4'd0) begin
        fam_q  = it.family_code;
        crc_q  = 8'h00;
        all_ff = 1'b1;
      end
      all_ff = all_ff && (it.data_byte == 8'hFF);
      case (idx)
        4'd0: reading_q[7:0]  = it.data_byte;
        4'd1: reading_q[15:8] = it.data_byte;
        4'd4: res_q    = it.data_byte;
        4'd6: remain_q = it.data_byte;
        4'd7: cpd_q    = it.data_byte;
        default: ;
      endcase
      if (idx < FRAME_LAST) begin
        crc_q = crc8_shift(crc_q, it.data_byte);
        pos   = idx + 4'd1;
      end else begin
        pos = FRAME_BYTES;
        res.temperature  = '0;
        res.computed_crc = crc_q;
        if (fam_q != FAM_A && fam_q != FAM_B && fam_q != FAM_C) begin
          res.status = ST_UNSUP;
        end else if (crc_q != it.data_byte) begin
          if (all_ff) begin
            res.status = ST_GONE;
          end else begin
            res.status = ST_CRC_ERR;
          end
        end else begin
          r = reading_q;
          if (fam_q == FAM_A) begin
            r = r << 3;
            // extended resolution from count-remain
            if (cpd_q == CPD_EXTENDED) begin
              r = (r & 16'hFFF0) + 16'd12 - {8'h00, remain_q};
            end
          end else begin
            case (res_q[6:5])
              RES_9B:  r[2:0] = 3'b000;
              RES_10B: r[1:0] = 2'b00;
              RES_11B: r[0]   = 1'b0;
              default: ;
            endcase
          end
          raw = int'($signed(r));
          case (unit_sel)
            UNIT_C:  t = raw;
            UNIT_K:  t = raw + KELVIN_16THS;
            default: t = (raw * 9 + F_BIAS_X5) / 5;
          endcase
          res.status      = ST_OK;
          res.temperature = t[16:0];
        end
        readings_due.push_back(res);
      end
    end
  endtask

  task automatic send_byte(input sdec_in_t it);
    bit counted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_reading(it, counted);
    if (counted) begin
      fed_cnt++;
    end
  endtask

  task automatic seal_pad();
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 8; i++) begin
      c = crc8_shift(c, pad[i]);
    end
    pad[8] = c;
  endtask

  task automatic fill_pad(input logic [7:0] fam, input logic [15:0] reading);
    pad[0] = reading[7:0];
    pad[1] = reading[15:8];
    for (int i = 2; i < 8; i++) begin
      pad[i] = 8'($urandom_range(255));
    end
    if (fam == FAM_A && $urandom_range(1) == 1) begin
      pad[7] = CPD_EXTENDED;
    end
    seal_pad();
  endtask

  // Family code only matters on byte zero; scramble it elsewhere
  task automatic send_pad(input logic [7:0] fam, input int n, input bit with_start);
    sdec_in_t it;
    for (int i = 0; i < n; i++) begin
      it.data_byte   = pad[i];
      it.family_code = (i == 0) ? fam : 8'($urandom_range(255));
      it.frame_start = (i == 0) && with_start;
      send_byte(it);
    end
  endtask

  task automatic send_noise(input int n);
    sdec_in_t it;
    for (int i = 0; i < n; i++) begin
      it.data_byte   = 8'($urandom_range(255));
      it.family_code = 8'($urandom_range(255));
      it.frame_start = 1'b0;
      send_byte(it);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_unit(input logic [1:0] u);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= u;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unit_sel  = u;
  endtask

  task automatic test_frame_without_start();
    fill_pad(FAM_B, 16'h7FFF);
    pad[4] = 8'h7F;
    seal_pad();
    send_pad(FAM_B, 9, 1'b0);
  endtask

  task automatic test_restart_mid_frame();
    fill_pad(FAM_A, 16'h0000);
    send_pad(FAM_A, 4, 1'b1);
    fill_pad(FAM_A, 16'h8000);
    pad[6] = 8'hFF;
    pad[7] = CPD_EXTENDED;
    seal_pad();
    send_pad(FAM_A, 9, 1'b1);
    // bytes past the ninth must be dropped
    send_noise(2);
  endtask

  task automatic test_status_cases();
    for (int i = 0; i < 9; i++) begin
      pad[i] = 8'hFF;
    end
    send_pad(FAM_C, 9, 1'b1);
    fill_pad(8'hFF, 16'hFFFF);
    send_pad(8'hFF, 9, 1'b1);
    fill_pad(FAM_B, 16'h0000);
    pad[4] = 8'h00;
    seal_pad();
    pad[8] = pad[8] ^ 8'h01;
    send_pad(FAM_B, 9, 1'b1);
  endtask

  task automatic random_frame();
    int          kind;
    logic [7:0]  fam;
    logic [15:0] reading;
    kind = $urandom_range(99);
    case ($urandom_range(2))
      0:       fam = FAM_A;
      1:       fam = FAM_B;
      default: fam = FAM_C;
    endcase
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       reading = 16'h0000;
        1:       reading = 16'h7FFF;
        2:       reading = 16'h8000;
        default: reading = 16'hFFFF;
      endcase
    end else begin
      reading = 16'($urandom_range(16'hFFFF));
    end
    if (kind >= 78 && kind < 84) begin
      do begin
        fam = 8'($urandom_range(255));
      end while (fam == FAM_A || fam == FAM_B || fam == FAM_C);
    end
    fill_pad(fam, reading);
    if (kind < 70 || (kind >= 78 && kind < 84)) begin
      send_pad(fam, 9, 1'b1);
    end else if (kind < 78) begin
      pad[8] = pad[8] ^ 8'($urandom_range(1, 255));
      send_pad(fam, 9, 1'b1);
    end else if (kind < 89) begin
      for (int i = 0; i < 9; i++) begin
        pad[i] = 8'hFF;
      end
      send_pad(fam, 9, 1'b1);
    end else if (kind < 95) begin
      send_pad(fam, $urandom_range(1, 8), 1'b1);
    end else begin
      send_pad(fam, 9, 1'b1);
      send_noise($urandom_range(1, 3));
    end
  endtask

  task automatic test_random(input logic [1:0] u, input int idle_pct, input int stall_p);
    int  start_cnt;
    bit  paused;
    set_unit(u);
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    start_cnt     = fed_cnt;
    paused        = 1'b0;
    while (fed_cnt - start_cnt < PHASE_BYTES) begin
      // hold off once per phase until the output side is empty
      if (!paused && fed_cnt - start_cnt >= PHASE_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      random_frame();
    end
  endtask

  // Result checking and receiver stall
  always @(posedge clk_i) begin
    sdec_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (readings_due.size() == 0) begin
        report_mismatch("result with no frame pending");
      end else begin
        want = readings_due.pop_front();
        results_seen++;
        st_seen[want.status]++;
        if (out_data_o.temperature !== want.temperature) begin
          report_mismatch($sformatf("temperature %0d, expected %0d",
                                    out_data_o.temperature, want.temperature));
        end
        if (out_data_o.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data_o.status, want.status));
        end
        if (out_data_o.computed_crc !== want.computed_crc) begin
          report_mismatch($sformatf("crc %02h, expected %02h",
                                    out_data_o.computed_crc, want.computed_crc));
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("[temp_sensor_scratchpad_decoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = UNIT_C;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_without_start();
    test_restart_mid_frame();
    test_status_cases();
    test_random(UNIT_C, 0, 0);
    test_random(UNIT_K, 87, 0);
    test_random(UNIT_F, 0, 87);
    test_random(UNIT_F_ALT, 20, 20);
    test_random(UNIT_F, 0, 0);
    wait_drained();

    $display("Fed %0d scratchpad bytes, checked %0d frame results over all four unit codes.",
             fed_cnt, results_seen);
    $display("Status mix: %0d ok, %0d crc error, %0d sensor gone, %0d unsupported family.",
             st_seen[ST_OK], st_seen[ST_CRC_ERR], st_seen[ST_GONE], st_seen[ST_UNSUP]);
    if (n_errors == 0) begin
      $display("[temp_sensor_scratchpad_decoder] OK");
    end else begin
      $display("[temp_sensor_scratchpad_decoder] ERROR");
    end
    $finish;
  end

endmodule
